FILE: hw/rtl/mtme_pkg.sv
// Package for the tag matching engine: queue depths, opcodes, entry layout, result word.
// No dependencies.
package mtme_pkg;
   localparam int POSTED_DEPTH     = 64;
   localparam int UNEXPECTED_DEPTH = 64;
   localparam int QUEUE_DEPTH      = (POSTED_DEPTH > UNEXPECTED_DEPTH) ?
                                     POSTED_DEPTH : UNEXPECTED_DEPTH;
   localparam int IDX_W            = $clog2(QUEUE_DEPTH);
   localparam int POS_W            = 7;

   typedef enum logic {OP_RECV = 1'b0, OP_MSG = 1'b1} opcode_type;

   typedef struct packed {
      logic [15:0] rank;
      logic        rank_wild;
      logic [31:0] tag;
      logic        tag_wild;
      logic [31:0] size;
      logic [31:0] handle;
   } entry_type;

   typedef struct packed {
      logic        valid;
      entry_type   ent;
   } slot_type;

   typedef struct packed {
      logic        hit;
      logic        full;
      logic [31:0] pos;
      entry_type   ent;
   } qstat_type;

   function automatic logic agrees(entry_type a, entry_type b);
      return (a.rank_wild || b.rank_wild || a.rank == b.rank) &&
             (a.tag_wild || b.tag_wild || a.tag == b.tag);
   endfunction
endpackage

FILE: hw/rtl/mtme_cell.sv
// One queue cell: holds one entry, compares it with the key, shifts from its neighbour.
// Depends on mtme_pkg.
module mtme_cell
   import mtme_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  entry_type key,
   input  logic      shift_en,
   input  slot_type  next_slot,
   input  logic      load_en,
   output slot_type  slot,
   output logic      match
);
   slot_type slot_ff, slot_in;

   assign slot  = slot_ff;
   assign match = slot_ff.valid && agrees(slot_ff.ent, key);

   always_comb begin
      slot_in = slot_ff;
      if (shift_en) slot_in = next_slot;
      else if (load_en) slot_in = '{valid: 1'b1, ent: key};
   end

   always_ff @(posedge clock) begin
      if (reset) slot_ff.valid <= 1'b0;
      else slot_ff.valid <= slot_in.valid;
      slot_ff.ent <= slot_in.ent;
   end
endmodule

FILE: hw/rtl/mtme_queue.sv
// Ordered queue as a chain of cells; registered first-match search, removal, append.
// Depends on mtme_pkg and mtme_cell.
module mtme_queue
   import mtme_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  entry_type        key,
   input  logic [IDX_W-1:0] last_idx,
   input  logic             remove_en,
   input  logic             append_en,
   output qstat_type        stat
);
   slot_type               slots [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] match, valid, after;
   logic [QUEUE_DEPTH-1:0] match_ff;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      slot_type nxt;
      logic     first_free;
      if (i == QUEUE_DEPTH - 1) begin : g_end
         assign nxt = '0;
         assign first_free = !valid[i] && valid[i-1];
      end else if (i == 0) begin : g_head
         assign nxt = slots[i+1];
         assign first_free = !valid[0];
      end else begin : g_mid
         assign nxt = slots[i+1];
         assign first_free = !valid[i] && valid[i-1];
      end
      assign valid[i] = slots[i].valid;
      mtme_cell u_cell (
         .clock, .reset, .key,
         .shift_en (remove_en && after[i]),
         .next_slot(nxt),
         .load_en  (append_en && first_free),
         .slot     (slots[i]),
         .match    (match[i])
      );
   end

   always_ff @(posedge clock) match_ff <= match;

   logic [QUEUE_DEPTH-1:0] first;
   assign first = match_ff & (~match_ff + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1});
   always_comb begin
      after[0] = first[0];
      for (int i = 1; i < QUEUE_DEPTH; i++) after[i] = after[i-1] | first[i];
   end

   always_comb begin
      stat      = '0;
      stat.hit  = |match_ff;
      stat.full = valid[last_idx];
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (first[i]) begin
            stat.pos = 32'(i + 1);
            stat.ent = slots[i].ent;
         end
      end
   end
endmodule

FILE: hw/rtl/message_tag_matching_engine_top.sv
// Top level of the tag matching engine: request register, two queues, result register.
// Depends on mtme_pkg, mtme_queue.
//
// Request channel req_*: one word per operation, opcode 0 posts a receive,
// opcode 1 delivers an arriving message. Result channel rsp_*: one word per
// request carrying found, enqueued, dropped_full, search position and the
// matched entry's handle and size.
// Each request passes a compare state and a resolve state: the compare state
// registers the compares in every cell of the opposite queue, the resolve
// state resolves the oldest match, closes the chain up or appends, and loads
// the result register, which raises rsp_valid. The next request is taken in
// the resolve cycle, while the result of the last one is being loaded.
// Reset empties both queues and the result register; cell contents are kept.
// When the receiver stalls the result holds, the resolve of the following
// request waits for the result register and no further request is taken.
module message_tag_matching_engine_top
   import mtme_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [15:0] req_source_rank,
   input  logic        req_source_wild,
   input  logic [31:0] req_tag_value,
   input  logic        req_tag_wild,
   input  logic [31:0] req_byte_count,
   input  logic [31:0] req_op_handle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic        rsp_enqueued,
   output logic        rsp_dropped_full,
   output logic [6:0]  rsp_search_depth,
   output logic [31:0] rsp_hit_handle,
   output logic [31:0] rsp_hit_size
);
   entry_type key_ff;
   logic      op_ff, busy_ff, resolve_ff, rv_ff;
   qstat_type pst, ust, sq;
   logic      fire, is_msg, p_rm, p_ap, u_rm, u_ap, aq_full;

   assign fire      = resolve_ff && (!rv_ff || rsp_ready);
   assign req_ready = !busy_ff && (!resolve_ff || fire);
   assign rsp_valid = rv_ff;

   assign is_msg  = (op_ff == OP_MSG);
   assign sq      = is_msg ? pst : ust;
   assign aq_full = is_msg ? ust.full : pst.full;
   assign p_rm = fire && is_msg && pst.hit;
   assign u_rm = fire && !is_msg && ust.hit;
   assign u_ap = fire && is_msg && !pst.hit && !ust.full;
   assign p_ap = fire && !is_msg && !ust.hit && !pst.full;

   mtme_queue u_posted (
      .clock, .reset, .key(key_ff), .last_idx(IDX_W'(POSTED_DEPTH - 1)),
      .remove_en(p_rm), .append_en(p_ap), .stat(pst));
   mtme_queue u_unexp (
      .clock, .reset, .key(key_ff), .last_idx(IDX_W'(UNEXPECTED_DEPTH - 1)),
      .remove_en(u_rm), .append_en(u_ap), .stat(ust));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         resolve_ff <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         busy_ff <= req_valid && req_ready;
         if (busy_ff) resolve_ff <= 1'b1;
         else if (fire) resolve_ff <= 1'b0;
         if (fire) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         op_ff  <= req_opcode;
         key_ff <= '{rank: req_source_rank, rank_wild: req_source_wild,
                     tag: req_tag_value, tag_wild: req_tag_wild,
                     size: req_byte_count, handle: req_op_handle};
      end
      if (fire) begin
         rsp_found        <= sq.hit;
         rsp_enqueued     <= !sq.hit && !aq_full;
         rsp_dropped_full <= !sq.hit && aq_full;
         rsp_search_depth <= sq.hit ? sq.pos[6:0] : 7'd0;
         rsp_hit_handle   <= sq.hit ? sq.ent.handle : 32'd0;
         rsp_hit_size     <= sq.hit ? sq.ent.size : 32'd0;
      end
   end
endmodule
